### src/mbrtu_pkg.sv
`timescale 1ns / 1ps

package mbrtu_pkg;

  // Deepest reply the value store holds.
  localparam int MaxRegs  = 32;
  localparam int MemAddrW = $clog2(MaxRegs);

  // Input modes
  localparam logic [1:0] ModeStart   = 2'd0;
  localparam logic [1:0] ModeRxByte  = 2'd1;
  localparam logic [1:0] ModeTimeout = 2'd2;

  // Result kinds
  localparam logic [1:0] KindTx     = 2'd0;
  localparam logic [1:0] KindRegVal = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  // Status codes
  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatTimeout   = 3'd1;
  localparam logic [2:0] StatCrcErr    = 3'd2;
  localparam logic [2:0] StatException = 3'd3;
  localparam logic [2:0] StatUnitErr   = 3'd4;
  localparam logic [2:0] StatCountErr  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgUnitId    = 2'd0;
  localparam logic [1:0] CfgStartAddr = 2'd1;
  localparam logic [1:0] CfgRegCount  = 2'd2;

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [7:0]  FuncExcFlag     = 8'h80;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [4:0]  reg_index;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  // One byte through the reflected CRC16, bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/modbus_rtu_read_holding_master_top.sv
`timescale 1ns / 1ps

// Modbus RTU master, function 0x03 (read holding registers).
// Input channel (in_valid_i / in_stall_o, in_word_i): one word per event:
// start request, received serial byte, or reply timeout.
// Output channel (out_valid_o / out_stall_i, out_word_o): transmit bytes,
// register values and status words; the final word of each run has last set.
// Config channel (cfg_valid_i / cfg_ready_o): unit id, start address and
// register count; always ready, write only while the block is idle.
// Sequence: a start emits the 8 request bytes one per cycle while the output
// is not stalled (CRC is built a byte per cycle as the bytes leave). A
// received byte is stored as it arrives. The byte that completes a frame is
// followed by a check state, then per register value a read of the value
// store and a load into the output register, and finally the status word.
// A timeout emits a status word, and is dropped when no reply is awaited.
// in_stall_o is high while a run is in progress; an output register
// decouples the sides, so a stalled receiver only holds the run in place.
// Reset returns the config registers to unit 1, address 2, count 3 and
// clears the frame state; the value store needs no clearing pass.
module modbus_rtu_read_holding_master_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mbrtu_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mbrtu_pkg::out_word_t  out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StTx   = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StRdA  = 3'd3;
  localparam logic [2:0] StRdV  = 3'd4;
  localparam logic [2:0] StStat = 3'd5;

  localparam logic [6:0] MaxFrameLen = 7'(5 + 2 * mbrtu_pkg::MaxRegs);

  // Configuration
  logic [7:0]  unit_id_q;
  logic [15:0] start_addr_q;
  logic [5:0]  reg_count_q;

  // Control and frame state
  logic [2:0]  state_q, state_d;
  logic        awaiting_q, awaiting_d;
  logic [6:0]  bytes_q, bytes_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  dly0_q, dly0_d, dly1_q, dly1_d;
  logic [7:0]  r_unit_q, r_unit_d;
  logic [7:0]  r_func_q, r_func_d;
  logic [7:0]  r_bcnt_q, r_bcnt_d;
  logic [7:0]  hi_q, hi_d;
  logic [2:0]  tx_idx_q, tx_idx_d;
  logic [4:0]  rd_idx_q, rd_idx_d;
  logic [2:0]  status_q, status_d;

  logic                  out_valid_q, out_valid_d;
  mbrtu_pkg::out_word_t  out_q, out_d;

  // Value store
  logic [15:0]                      mem_q [mbrtu_pkg::MaxRegs];
  logic                             mem_we;
  logic [mbrtu_pkg::MemAddrW-1:0]   mem_waddr;
  logic [15:0]                      mem_wdata;
  logic                             mem_re;
  logic [15:0]                      mem_rdata_q;

  logic        in_acc;
  logic        out_free;
  logic [5:0]  cnt;
  logic [6:0]  expected;
  logic [5:0]  vi;
  logic [7:0]  tx_byte;
  logic [15:0] crc_feed_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Clamp the count into 1..MaxRegs.
  always_comb begin
    if (reg_count_q == 6'd0) begin
      cnt = 6'd1;
    end else if (reg_count_q > 6'(mbrtu_pkg::MaxRegs)) begin
      cnt = 6'(mbrtu_pkg::MaxRegs);
    end else begin
      cnt = reg_count_q;
    end
  end

  assign expected = 7'd5 + {cnt, 1'b0};
  assign vi       = 6'(bytes_q[6:1] - 6'd2);

  always_comb begin
    unique case (tx_idx_q)
      3'd0:    tx_byte = unit_id_q;
      3'd1:    tx_byte = mbrtu_pkg::FuncReadHolding;
      3'd2:    tx_byte = start_addr_q[15:8];
      3'd3:    tx_byte = start_addr_q[7:0];
      3'd4:    tx_byte = 8'h00;
      3'd5:    tx_byte = {2'b00, cnt};
      3'd6:    tx_byte = crc_q[7:0];
      default: tx_byte = crc_q[15:8];
    endcase
  end

  // One CRC unit, shared by the request and the reply.
  assign crc_feed_out = mbrtu_pkg::crc_feed(crc_q, (state_q == StTx) ? tx_byte : dly1_q);

  always_comb begin
    state_d     = state_q;
    awaiting_d  = awaiting_q;
    bytes_d     = bytes_q;
    crc_d       = crc_q;
    dly0_d      = dly0_q;
    dly1_d      = dly1_q;
    r_unit_d    = r_unit_q;
    r_func_d    = r_func_q;
    r_bcnt_d    = r_bcnt_q;
    hi_d        = hi_q;
    tx_idx_d    = tx_idx_q;
    rd_idx_d    = rd_idx_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = vi[mbrtu_pkg::MemAddrW-1:0];
    mem_wdata   = {hi_q, in_word_i.rx_byte};
    mem_re      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_word_i.mode)
            mbrtu_pkg::ModeStart: begin
              // Abandon any pending reply and send a fresh request.
              state_d    = StTx;
              tx_idx_d   = 3'd0;
              crc_d      = mbrtu_pkg::CrcInit;
              awaiting_d = 1'b1;
              bytes_d    = 7'd0;
              dly0_d     = 8'h00;
              dly1_d     = 8'h00;
            end
            mbrtu_pkg::ModeTimeout: begin
              if (awaiting_q) begin
                awaiting_d = 1'b0;
                status_d   = mbrtu_pkg::StatTimeout;
                state_d    = StStat;
              end
            end
            mbrtu_pkg::ModeRxByte: begin
              if (awaiting_q) begin
                // Feed the CRC two bytes late so the trailing CRC stays out.
                if (bytes_q >= 7'd2) begin
                  crc_d = crc_feed_out;
                end
                dly1_d = dly0_q;
                dly0_d = in_word_i.rx_byte;
                if (bytes_q == 7'd0) begin
                  r_unit_d = in_word_i.rx_byte;
                end else if (bytes_q == 7'd1) begin
                  r_func_d = in_word_i.rx_byte;
                end else if (bytes_q == 7'd2) begin
                  r_bcnt_d = in_word_i.rx_byte;
                end else if (bytes_q[0]) begin
                  hi_d = in_word_i.rx_byte;
                end else begin
                  mem_we = (vi < 6'(mbrtu_pkg::MaxRegs));
                end
                bytes_d = bytes_q + 7'd1;
                if (bytes_d >= expected) begin
                  awaiting_d = 1'b0;
                  state_d    = StChk;
                end
              end
            end
            default: begin
              // Unused mode: drop the word.
            end
          endcase
        end
      end

      StTx: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mbrtu_pkg::KindTx;
          out_d.data      = {8'h00, tx_byte};
          out_d.reg_index = 5'd0;
          out_d.status    = mbrtu_pkg::StatOk;
          out_d.last      = (tx_idx_q == 3'd7);
          tx_idx_d        = tx_idx_q + 3'd1;
          if (tx_idx_q < 3'd6) begin
            crc_d = crc_feed_out;
          end
          if (tx_idx_q == 3'd7) begin
            crc_d   = mbrtu_pkg::CrcInit;
            state_d = StIdle;
          end
        end
      end

      StChk: begin
        rd_idx_d = 5'd0;
        if ({dly0_q, dly1_q} != crc_q) begin
          status_d = mbrtu_pkg::StatCrcErr;
          state_d  = StStat;
        end else if (r_func_q >= mbrtu_pkg::FuncExcFlag) begin
          status_d = mbrtu_pkg::StatException;
          state_d  = StStat;
        end else if (r_unit_q != unit_id_q) begin
          status_d = mbrtu_pkg::StatUnitErr;
          state_d  = StStat;
        end else if (r_bcnt_q != {1'b0, cnt, 1'b0}) begin
          status_d = mbrtu_pkg::StatCountErr;
          state_d  = StStat;
        end else begin
          status_d = mbrtu_pkg::StatOk;
          state_d  = StRdA;
        end
      end

      StRdA: begin
        mem_re  = 1'b1;
        state_d = StRdV;
      end

      StRdV: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mbrtu_pkg::KindRegVal;
          out_d.data      = mem_rdata_q;
          out_d.reg_index = rd_idx_q;
          out_d.status    = mbrtu_pkg::StatOk;
          out_d.last      = 1'b0;
          rd_idx_d        = rd_idx_q + 5'd1;
          if ({1'b0, rd_idx_q} == 6'(cnt - 6'd1)) begin
            state_d = StStat;
          end else begin
            state_d = StRdA;
          end
        end
      end

      StStat: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mbrtu_pkg::KindStatus;
          out_d.data      = {9'h000, bytes_q};
          out_d.reg_index = 5'd0;
          out_d.status    = status_q;
          out_d.last      = 1'b1;
          state_d         = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_id_q    <= 8'd1;
      start_addr_q <= 16'd2;
      reg_count_q  <= 6'd3;
      state_q      <= StIdle;
      awaiting_q   <= 1'b0;
      bytes_q      <= 7'd0;
      crc_q        <= mbrtu_pkg::CrcInit;
      dly0_q       <= 8'h00;
      dly1_q       <= 8'h00;
      r_unit_q     <= 8'h00;
      r_func_q     <= 8'h00;
      r_bcnt_q     <= 8'h00;
      hi_q         <= 8'h00;
      tx_idx_q     <= 3'd0;
      rd_idx_q     <= 5'd0;
      status_q     <= mbrtu_pkg::StatOk;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mbrtu_pkg::CfgUnitId:    unit_id_q    <= cfg_data_i[7:0];
          mbrtu_pkg::CfgStartAddr: start_addr_q <= cfg_data_i;
          mbrtu_pkg::CfgRegCount:  reg_count_q  <= cfg_data_i[5:0];
          default: begin
            // Unmapped index: drop the write.
          end
        endcase
      end
      state_q     <= state_d;
      awaiting_q  <= awaiting_d;
      bytes_q     <= bytes_d;
      crc_q       <= crc_d;
      dly0_q      <= dly0_d;
      dly1_q      <= dly1_d;
      r_unit_q    <= r_unit_d;
      r_func_q    <= r_func_d;
      r_bcnt_q    <= r_bcnt_d;
      hi_q        <= hi_d;
      tx_idx_q    <= tx_idx_d;
      rd_idx_q    <= rd_idx_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[rd_idx_q];
    end
  end

  // A frame never runs past the longest reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bytes_q <= MaxFrameLen)
    else $error("received byte count beyond longest frame");

  // Register values never close a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == mbrtu_pkg::KindRegVal) |-> !out_q.last)
    else $error("register value marked last");

  // Reply is closed before the value store is read back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRdA) || (state_q == StRdV) || (state_q == StChk) |-> !awaiting_q)
    else $error("reading values while reply still open");

  // Sending the request always leaves the block waiting for a reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTx) |-> awaiting_q && (bytes_q == 7'd0))
    else $error("request in flight without a fresh reply window");

  // A read is issued only when the store comes back next cycle for loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRdA) |=> (state_q == StRdV) && $stable(rd_idx_q))
    else $error("value read not followed by load");

endmodule
